// ----- rtl/tllc_pkg.sv -----
// Package for the timestamp-LRU line tag cache.
// Holds the sizes, widths and clock limit shared by the cache core.
// Depends on nothing.
package tllc_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
	localparam int CNT_BITS   = $clog2(NUM_SLOTS + 1);
	localparam int LINE_BITS  = 20;
	localparam int STAMP_BITS = 17;
	localparam int CAP_BITS   = 5;

	localparam logic [STAMP_BITS-1:0] CLOCK_LIMIT = STAMP_BITS'(65535);

	typedef logic [LINE_BITS-1:0]  line_t;
	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [SLOT_BITS-1:0]  slot_t;
	typedef logic [CNT_BITS-1:0]   count_t;

endpackage

// ----- rtl/timestamp_lru_line_tag_cache_core.sv -----
// Each accepted input word passes through an accept in the idle state, a scan over the 16 slots
// in order and a commit that writes its result word; a new word is refused until that commit.
// The single tag/stamp compare unit is stepped once per slot by the scan counter.
// A new word is taken while a finished result still waits; the commit holds until it drains.
// Reset (asynchronous, active low) empties the cache, zeroes the clock and stamps,
// and sets the capacity to 1. No clearing pass is needed.
module timestamp_lru_line_tag_cache_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_we,
	input  logic [tllc_pkg::CAP_BITS-1:0]          cfg_wdata,
	// request channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [tllc_pkg::LINE_BITS-1:0]         line_number,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   hit,
	output logic [tllc_pkg::SLOT_BITS-1:0]         slot,
	output logic                                   evicted_valid,
	output logic [tllc_pkg::LINE_BITS-1:0]         evicted_line
);
	import tllc_pkg::*;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [1:0]          state_q;
	logic [CAP_BITS-1:0] cap_q;
	stamp_t              clock_q;

	// Cache state: tags, stamps and valid bits, one entry per slot.
	line_t               tag_q   [NUM_SLOTS];
	stamp_t              stamp_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;

	// Request being worked on and the scan results gathered so far.
	line_t               line_q;
	slot_t               idx_q;
	count_t              held_q;
	logic                found_q;
	slot_t               found_idx_q;
	logic                free_found_q;
	slot_t               free_idx_q;
	logic                vic_any_q;
	slot_t               vic_idx_q;
	stamp_t              best_stamp_q;
	line_t               best_tag_q;

	// Result register.
	logic                out_valid_q;
	logic                hit_q;
	slot_t               slot_q;
	logic                ev_valid_q;
	line_t               ev_line_q;

	// The shared compare unit looks at one slot per cycle.
	logic                cur_valid;
	line_t               cur_tag;
	stamp_t              cur_stamp;
	logic                tag_match;
	logic                older;

	count_t              eff_cap;
	logic                use_free;
	slot_t               slot_sel;
	logic                commit;
	logic                accept;
	logic                wrap;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign cur_valid = valid_q[idx_q];
	assign cur_tag   = tag_q[idx_q];
	assign cur_stamp = stamp_q[idx_q];
	assign tag_match = (cur_tag == line_q);

	// All entries share the same clock, so the greatest age is the smallest stamp.
	// Equal stamps fall back to the smaller line number.
	assign older = !vic_any_q || (cur_stamp < best_stamp_q) ||
	               ((cur_stamp == best_stamp_q) && (cur_tag < best_tag_q));

	// A capacity of zero acts as one, anything above the slot count as the slot count.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = count_t'(1);
		end else if (cap_q > CAP_BITS'(NUM_SLOTS)) begin
			eff_cap = count_t'(NUM_SLOTS);
		end else begin
			eff_cap = count_t'(cap_q);
		end
	end

	assign use_free = !found_q && (held_q < eff_cap) && free_found_q;

	always_comb begin
		priority if (found_q) begin
			slot_sel = found_idx_q;
		end else if (use_free) begin
			slot_sel = free_idx_q;
		end else begin
			slot_sel = vic_idx_q;
		end
	end

	// The commit waits only while an older result is still stalled at the output.
	assign commit = (state_q == ST_WRITE) && (!out_valid_q || !out_stall);
	assign wrap   = commit && (clock_q > CLOCK_LIMIT);

	// Sequencer, scan bookkeeping, clock and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_BITS'(1);
			clock_q      <= '0;
			idx_q        <= '0;
			held_q       <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_any_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_SCAN;
						idx_q        <= '0;
						held_q       <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						vic_any_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cur_valid) begin
						held_q <= held_q + count_t'(1);
						if (!found_q && tag_match) begin
							found_q <= 1'b1;
						end
						if (older) begin
							vic_any_q <= 1'b1;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (idx_q == slot_t'(NUM_SLOTS - 1)) begin
						state_q <= ST_WRITE;
					end else begin
						idx_q <= idx_q + slot_t'(1);
					end
				end
				ST_WRITE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						idx_q   <= '0;
						if (clock_q > CLOCK_LIMIT) begin
							clock_q <= stamp_t'(1);
						end else begin
							clock_q <= clock_q + stamp_t'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan payload registers: the request and the best candidates found so far.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= line_number;
		end
		if (state_q == ST_SCAN) begin
			if (cur_valid) begin
				if (!found_q && tag_match) begin
					found_idx_q <= idx_q;
				end
				if (older) begin
					vic_idx_q    <= idx_q;
					best_stamp_q <= cur_stamp;
					best_tag_q   <= cur_tag;
				end
			end else if (!free_found_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	// Tags are only read where the valid bit is set, so they need no reset.
	always_ff @(posedge clk) begin
		if (commit) begin
			tag_q[slot_sel] <= line_q;
		end
	end

	// Valid bits and stamps. A clock wrap clears every stamp, the fresh one included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				stamp_q[i] <= '0;
			end
		end else begin
			if (commit) begin
				valid_q[slot_sel] <= 1'b1;
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (wrap) begin
					stamp_q[i] <= '0;
				end else if (commit && (slot_sel == slot_t'(i))) begin
					stamp_q[i] <= clock_q;
				end
			end
		end
	end

	// Result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q      <= found_q;
			slot_q     <= slot_sel;
			ev_valid_q <= !found_q && !use_free;
			ev_line_q  <= (!found_q && !use_free) ? best_tag_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_line  = ev_line_q;

`ifndef SYNTHESIS
	// An eviction always has a held line to displace.
	a_victim_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !found_q && !use_free) |-> vic_any_q)
		else $error("eviction without a valid victim");

	// The held count gathered by the scan never exceeds the slot count.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (held_q <= count_t'(NUM_SLOTS)))
		else $error("held count out of range");

	// After a commit the chosen slot is held.
	a_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> valid_q[$past(slot_sel)])
		else $error("committed slot not marked valid");

	// The clock never runs past one step beyond its limit.
	a_clock_bound: assert property (@(posedge clk) disable iff (!arst_n)
		clock_q <= (CLOCK_LIMIT + stamp_t'(1)))
		else $error("clock beyond its limit");

	// The scan counter rests at zero between requests.
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("scan index not at zero while idle");
`endif

endmodule
